// ===== rtl/i2a_pkg.sv =====
// Shared types, constants and helpers of the integer-to-ASCII formatter.
// Depends on nothing; every other file of the block imports it.
package i2a_pkg;

    // Fixed payload widths of the number and text channels
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 64;
    localparam int WIDTH_W = 6;
    localparam int CHAR_W  = 7;

    // Mode codes on func; bit 1 set selects pointer mode
    localparam logic [FUNC_W-1:0] FUNC_DEC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HEX = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PTR = 2'd2;

    // Field width used by pointer mode when none is requested
    localparam logic [WIDTH_W-1:0] PTR_DEFAULT_WIDTH = 6'd8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CH_A_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_X_LOWER = 7'h78;

    // Control part of a converted number, passed from converter to emitter
    typedef struct packed {
        logic               is_hex;
        logic               is_ptr;
        logic               neg;
        logic [WIDTH_W-1:0] width;
    } job_ctrl_t;

    // Map one digit nibble (BCD or hex) to its lowercase ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CH_A_LOWER + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// ===== rtl/i2a_if.sv =====
// Valid/ready channel interfaces of the formatter: numbers in, characters out.
// Depends on i2a_pkg for the payload widths.
interface i2a_num_if import i2a_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0] width;
    logic               width_given;

    modport source (output valid, func, value, width, width_given, input ready);
    modport sink   (input valid, func, value, width, width_given, output ready);
endinterface

interface i2a_text_if import i2a_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last;

    modport source (output valid, char_out, last, input ready);
    modport sink   (input valid, char_out, last, output ready);
endinterface

// ===== rtl/i2a_conv.sv =====
// Converter: takes a number transfer, builds its digit nibbles with a shared
// shift-and-add-3 unit (decimal) or a direct load (hex), then finds the digit count.
// Depends on i2a_pkg and i2a_num_if.
module i2a_conv import i2a_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_WIDTH  = 62
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    i2a_num_if.sink                         number,
    output logic                            job_valid,
    input  logic                            job_ready,
    output job_ctrl_t                       job_ctrl,
    output logic [4*((VALUE_BITS*302)/1000+1)-1:0]         job_digits,
    output logic [$clog2((VALUE_BITS*302)/1000+2)-1:0]     job_nd
);

    localparam int NDIG  = (VALUE_BITS * 302) / 1000 + 1;
    localparam int DIG_W = 4 * NDIG;
    localparam int POS_W = $clog2(NDIG);
    localparam int ND_W  = $clog2(NDIG + 1);
    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_SHIFT = 4'b0010,
        C_SCAN  = 4'b0100,
        C_HAND  = 4'b1000
    } conv_state_t;

    conv_state_t             state_reg, state_next;
    logic [DIG_W-1:0]        dig_reg, dig_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [ND_W-1:0]         nd_reg, nd_next;
    job_ctrl_t               ctrl_reg, ctrl_next;

    logic                    in_xfer;
    logic [VALUE_BITS-1:0]   in_v;
    logic                    in_ptr;
    logic                    in_hex;
    logic                    in_neg;
    logic [WIDTH_W-1:0]      in_w;
    logic [DIG_W-1:0]        dig_adj;
    logic [3:0]              dig_sel;
    logic                    bcd_ok;

    assign number.ready = (state_reg == C_IDLE);
    assign in_xfer      = number.valid && number.ready;

    // Decode the incoming transfer
    always_comb
    begin
        in_v   = number.value[VALUE_BITS-1:0];
        in_ptr = number.func[1];
        in_hex = (number.func == FUNC_HEX) || in_ptr;
        in_neg = !in_hex && in_v[VALUE_BITS-1];
        if (!number.width_given)
        begin
            in_w = in_ptr ? PTR_DEFAULT_WIDTH : '0;
        end
        else
        begin
            in_w = number.width;
        end
        if (in_w > WIDTH_W'(MAX_WIDTH))
        begin
            in_w = WIDTH_W'(MAX_WIDTH);
        end
    end

    // Shared double-dabble unit: add 3 to every digit of 5 or more
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[4*i +: 4] >= 4'd5)
            begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                dig_adj[4*i +: 4] = dig_reg[4*i +: 4];
            end
        end
    end

    // Digit under the scan pointer
    assign dig_sel = dig_reg[{pos_reg, 2'b00} +: 4];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        nd_next    = nd_reg;
        ctrl_next  = ctrl_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_xfer)
                begin
                    ctrl_next.is_hex = in_hex;
                    ctrl_next.is_ptr = in_ptr;
                    ctrl_next.neg    = in_neg;
                    ctrl_next.width  = in_w;
                    pos_next         = POS_W'(NDIG - 1);
                    cnt_next         = CNT_W'(VALUE_BITS - 1);
                    if (in_hex)
                    begin
                        dig_next   = DIG_W'(in_v);
                        state_next = C_SCAN;
                    end
                    else
                    begin
                        dig_next   = '0;
                        mag_next   = in_neg ? (VALUE_BITS'(0) - in_v) : in_v;
                        state_next = C_SHIFT;
                    end
                end
            end
            C_SHIFT:
            begin
                // Adjust, then shift in the next magnitude bit
                dig_next = {dig_adj[DIG_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = C_SCAN;
                end
            end
            C_SCAN:
            begin
                // Drop leading zero digits, keep at least one
                if (dig_sel == 4'd0 && pos_reg != '0)
                begin
                    pos_next = pos_reg - 1'b1;
                end
                else
                begin
                    nd_next    = ND_W'(pos_reg) + 1'b1;
                    state_next = C_HAND;
                end
            end
            C_HAND:
            begin
                if (job_ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        mag_reg  <= mag_next;
        cnt_reg  <= cnt_next;
        pos_reg  <= pos_next;
        nd_reg   <= nd_next;
        ctrl_reg <= ctrl_next;
    end

    assign job_valid  = (state_reg == C_HAND);
    assign job_ctrl   = ctrl_reg;
    assign job_digits = dig_reg;
    assign job_nd     = nd_reg;

    // All digits are proper BCD once decimal conversion is done
    always_comb
    begin
        bcd_ok = 1'b1;
        for (int i = 0; i < NDIG; i++)
        begin
            if (dig_reg[4*i +: 4] > 4'd9)
            begin
                bcd_ok = 1'b0;
            end
        end
    end

    a_shift_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_SHIFT && cnt_reg != '0) |=> state_reg == C_SHIFT)
        else $error("conversion left the shift loop early");

    a_scan_skips_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_SCAN && dig_sel == 4'd0 && pos_reg != '0) |=> state_reg == C_SCAN)
        else $error("scan stopped on a leading zero digit");

    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_SCAN && !ctrl_reg.is_hex) |-> bcd_ok)
        else $error("decimal conversion produced a digit above nine");

endmodule

// ===== rtl/i2a_emit.sv =====
// Emitter: walks prefix, padding, sign and digits of one converted number and
// sends one character per text transfer through an output register.
// Depends on i2a_pkg and i2a_text_if.
module i2a_emit import i2a_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           job_valid,
    output logic                                           job_ready,
    input  job_ctrl_t                                      job_ctrl,
    input  logic [4*((VALUE_BITS*302)/1000+1)-1:0]         job_digits,
    input  logic [$clog2((VALUE_BITS*302)/1000+2)-1:0]     job_nd,
    i2a_text_if.source                                     text
);

    localparam int NDIG   = (VALUE_BITS * 302) / 1000 + 1;
    localparam int DIG_W  = 4 * NDIG;
    localparam int POS_W  = $clog2(NDIG);
    localparam int BODY_W = WIDTH_W + 1;

    typedef enum logic [5:0] {
        E_IDLE  = 6'b000001,
        E_PFX0  = 6'b000010,
        E_PFX1  = 6'b000100,
        E_PAD   = 6'b001000,
        E_SIGN  = 6'b010000,
        E_DIGIT = 6'b100000
    } emit_state_t;

    emit_state_t          state_reg, state_next;
    logic [DIG_W-1:0]     dig_reg, dig_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WIDTH_W-1:0]   pad_reg, pad_next;
    job_ctrl_t            ctrl_reg, ctrl_next;
    logic                 ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic                 job_xfer;
    logic [BODY_W-1:0]    body;
    logic [BODY_W-1:0]    wide;
    logic [WIDTH_W-1:0]   job_pad;
    logic                 adv;
    logic [CHAR_W-1:0]    cur_char;
    logic                 cur_last;

    assign job_ready = (state_reg == E_IDLE);
    assign job_xfer  = job_valid && job_ready;

    // Padding = requested width minus sign and digits, if positive
    always_comb
    begin
        body = BODY_W'(job_nd) + BODY_W'(job_ctrl.neg);
        wide = {1'b0, job_ctrl.width};
        if (wide > body)
        begin
            job_pad = WIDTH_W'(wide - body);
        end
        else
        begin
            job_pad = '0;
        end
    end

    // Advance when a character can move into the output register
    assign adv = (state_reg != E_IDLE) && (!ovalid_reg || text.ready);

    // Character of the current step
    always_comb
    begin
        cur_last = 1'b0;
        unique case (state_reg)
            E_PFX0:  cur_char = CH_ZERO;
            E_PFX1:  cur_char = CH_X_LOWER;
            E_PAD:   cur_char = ctrl_reg.is_hex ? CH_ZERO : CH_SPACE;
            E_SIGN:  cur_char = CH_MINUS;
            E_DIGIT:
            begin
                cur_char = digit_char(dig_reg[{pos_reg, 2'b00} +: 4]);
                cur_last = (pos_reg == '0);
            end
            default: cur_char = CH_SPACE;
        endcase
    end

    // Step sequencer
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        pos_next   = pos_reg;
        pad_next   = pad_reg;
        ctrl_next  = ctrl_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (job_xfer)
                begin
                    dig_next  = job_digits;
                    pos_next  = POS_W'(job_nd - 1'b1);
                    pad_next  = job_pad;
                    ctrl_next = job_ctrl;
                    if (job_ctrl.is_ptr)
                    begin
                        state_next = E_PFX0;
                    end
                    else if (job_pad != '0)
                    begin
                        state_next = E_PAD;
                    end
                    else if (job_ctrl.neg)
                    begin
                        state_next = E_SIGN;
                    end
                    else
                    begin
                        state_next = E_DIGIT;
                    end
                end
            end
            E_PFX0:
            begin
                if (adv)
                begin
                    state_next = E_PFX1;
                end
            end
            E_PFX1:
            begin
                if (adv)
                begin
                    if (pad_reg != '0)
                    begin
                        state_next = E_PAD;
                    end
                    else if (ctrl_reg.neg)
                    begin
                        state_next = E_SIGN;
                    end
                    else
                    begin
                        state_next = E_DIGIT;
                    end
                end
            end
            E_PAD:
            begin
                if (adv)
                begin
                    pad_next = pad_reg - 1'b1;
                    if (pad_reg == WIDTH_W'(1))
                    begin
                        state_next = ctrl_reg.neg ? E_SIGN : E_DIGIT;
                    end
                end
            end
            E_SIGN:
            begin
                if (adv)
                begin
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT:
            begin
                if (adv)
                begin
                    if (pos_reg == '0)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // Output register: load on advance, drop valid once transferred
    always_comb
    begin
        ovalid_next = ovalid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (adv)
        begin
            ovalid_next = 1'b1;
            char_next   = cur_char;
            last_next   = cur_last;
        end
        else if (text.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        pos_reg  <= pos_next;
        pad_reg  <= pad_next;
        ctrl_reg <= ctrl_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.valid    = ovalid_reg;
    assign text.char_out = char_reg;
    assign text.last     = last_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cur_last) |=> state_reg == E_IDLE)
        else $error("emitter kept running after the last character");

    a_pad_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_PAD && adv && pad_reg != WIDTH_W'(1)) |=> state_reg == E_PAD)
        else $error("padding ended before its count ran out");

    a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
        job_xfer |=> state_reg != E_IDLE)
        else $error("accepted number produced no characters");

endmodule

// ===== rtl/integer_to_ascii_formatter_core.sv =====
// Integer-to-ASCII formatter, top level: converter feeding the character emitter.
// Depends on i2a_pkg, i2a_if, i2a_conv and i2a_emit.
//
// Each number transfer yields 1 to 64 character transfers, most significant
// first, with last set on the final one. A decimal number is accepted, passes
// all VALUE_BITS magnitude bits through the shared shift-and-add-3 unit, then
// the leading-zero scan over up to NDIG digits (20 at 64 bits), and is then
// handed off; hex and pointer skip the shift loop. The emitter then sends
// one character per cycle while the text side is ready. The converter takes
// the next number as soon as it has handed off the previous one, so
// conversion overlaps emission.
module integer_to_ascii_formatter_core import i2a_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_WIDTH  = 62
)
(
    input  logic        clk,
    input  logic        rst_n,
    i2a_num_if.sink     number,
    i2a_text_if.source  text
);

    localparam int NDIG = (VALUE_BITS * 302) / 1000 + 1;
    localparam int ND_W = $clog2(NDIG + 1);

    logic               job_valid;
    logic               job_ready;
    job_ctrl_t          job_ctrl;
    logic [4*NDIG-1:0]  job_digits;
    logic [ND_W-1:0]    job_nd;

    // Digit conversion
    i2a_conv #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .number     (number),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_ctrl   (job_ctrl),
        .job_digits (job_digits),
        .job_nd     (job_nd)
    );

    // Character output
    i2a_emit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job_ctrl   (job_ctrl),
        .job_digits (job_digits),
        .job_nd     (job_nd),
        .text       (text)
    );

endmodule
